>>> sv/sbf_pkg.sv
`timescale 1ns / 1ps
// Shared constants and types for the spring and bungee force pipeline.
// Used by sbf_sqrt, sbf_div and spring_bungee_force.
package sbf_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int COORD_W = 32;
    localparam int DIFF_W = COORD_W + 1;
    localparam int SQ_SUM_W = 2 * DIFF_W;
    localparam int ROOT_W = DIFF_W + 1;
    localparam int LANES = 3;

    localparam int REG_IDX_W = 1;
    localparam logic [REG_IDX_W-1:0] REG_SPRING_K = 1'd0;
    localparam logic [REG_IDX_W-1:0] REG_REST_LEN = 1'd1;
    localparam logic [COORD_W-1:0] CFG_RESET_VAL = 32'h0001_0000;

    typedef struct packed {
        logic             slack;
        logic             zero;
        logic             fneg;
        logic [LANES-1:0] dneg;
    } sbf_flags_t;

endpackage

>>> sv/sbf_sqrt.sv
`timescale 1ns / 1ps
// Pipelined integer square root, one result bit per register stage.
// Depends on sbf_pkg for the root width; carries an opaque sideband with each item.
module sbf_sqrt #(
    parameter int SW = 1
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [2*sbf_pkg::ROOT_W-1:0]  in_rad,
    input  logic [SW-1:0]                 in_side,
    output logic                          out_valid,
    output logic [sbf_pkg::ROOT_W-1:0]    out_root,
    output logic [SW-1:0]                 out_side
);
    import sbf_pkg::*;

    localparam int RW = ROOT_W + 2;

    logic                  valid_reg [ROOT_W];
    logic [RW-1:0]         rem_reg   [ROOT_W];
    logic [ROOT_W-1:0]     root_reg  [ROOT_W];
    logic [2*ROOT_W-1:0]   rad_reg   [ROOT_W];
    logic [SW-1:0]         side_reg  [ROOT_W];

    for (genvar i = 0; i < ROOT_W; i++) begin : g_st
        logic                valid_in;
        logic [RW-1:0]       rem_in;
        logic [ROOT_W-1:0]   root_in;
        logic [2*ROOT_W-1:0] rad_in;
        logic [SW-1:0]       side_in;
        logic [RW+1:0]       cand;
        logic [RW+1:0]       trial;
        logic                take;
        logic [RW-1:0]       rem_next;
        logic [ROOT_W-1:0]   root_next;

        if (i == 0) begin : g_first
            assign valid_in = in_valid;
            assign rem_in   = '0;
            assign root_in  = '0;
            assign rad_in   = in_rad;
            assign side_in  = in_side;
        end else begin : g_rest
            assign valid_in = valid_reg[i-1];
            assign rem_in   = rem_reg[i-1];
            assign root_in  = root_reg[i-1];
            assign rad_in   = rad_reg[i-1];
            assign side_in  = side_reg[i-1];
        end

        assign cand      = {rem_in, rad_in[2*ROOT_W-1 -: 2]};
        assign trial     = {2'b00, root_in, 2'b01};
        assign take      = cand >= trial;
        assign rem_next  = take ? RW'(cand - trial) : cand[RW-1:0];
        assign root_next = {root_in[ROOT_W-2:0], take};

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[i] <= 1'b0;
            end else if (en) begin
                valid_reg[i] <= valid_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[i]  <= rem_next;
                root_reg[i] <= root_next;
                rad_reg[i]  <= {rad_in[2*ROOT_W-3:0], 2'b00};
                side_reg[i] <= side_in;
            end
        end
    end

    assign out_valid = valid_reg[ROOT_W-1];
    assign out_root  = root_reg[ROOT_W-1];
    assign out_side  = side_reg[ROOT_W-1];

endmodule

>>> sv/sbf_div.sv
`timescale 1ns / 1ps
// Pipelined restoring divider for three lanes sharing one divisor, one quotient
// bit per stage. Depends on sbf_pkg for the lane count.
module sbf_div #(
    parameter int QB = 17,
    parameter int DW = 34,
    parameter int NW = 49,
    parameter int SW = 1
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic          in_valid,
    input  logic [NW-1:0] in_num [sbf_pkg::LANES],
    input  logic [DW-1:0] in_den,
    input  logic [SW-1:0] in_side,
    output logic          out_valid,
    output logic [QB-1:0] out_quo [sbf_pkg::LANES],
    output logic [SW-1:0] out_side
);
    import sbf_pkg::*;

    localparam int RW = DW + QB;

    logic          valid_reg [QB];
    logic [DW-1:0] den_reg   [QB];
    logic [SW-1:0] side_reg  [QB];
    logic [RW-1:0] rem_reg   [QB][LANES];
    logic [QB-1:0] quo_reg   [QB][LANES];

    for (genvar j = 0; j < QB; j++) begin : g_st
        localparam int BITPOS = QB - 1 - j;
        logic          valid_in;
        logic [DW-1:0] den_in;
        logic [SW-1:0] side_in;
        logic [RW-1:0] dsh;

        if (j == 0) begin : g_first
            assign valid_in = in_valid;
            assign den_in   = in_den;
            assign side_in  = in_side;
        end else begin : g_rest
            assign valid_in = valid_reg[j-1];
            assign den_in   = den_reg[j-1];
            assign side_in  = side_reg[j-1];
        end

        assign dsh = RW'(den_in) << BITPOS;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[j] <= 1'b0;
            end else if (en) begin
                valid_reg[j] <= valid_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                den_reg[j]  <= den_in;
                side_reg[j] <= side_in;
            end
        end

        for (genvar l = 0; l < LANES; l++) begin : g_lane
            logic [RW-1:0] rem_in;
            logic [QB-1:0] quo_in;
            logic          take;

            if (j == 0) begin : g_first
                assign rem_in = RW'(in_num[l]);
                assign quo_in = '0;
            end else begin : g_rest
                assign rem_in = rem_reg[j-1][l];
                assign quo_in = quo_reg[j-1][l];
            end

            assign take = rem_in >= dsh;

            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[j][l] <= take ? (rem_in - dsh) : rem_in;
                    quo_reg[j][l] <= {quo_in[QB-2:0], take};
                end
            end
        end
    end

    assign out_valid = valid_reg[QB-1];
    assign out_side  = side_reg[QB-1];
    for (genvar l = 0; l < LANES; l++) begin : g_out
        assign out_quo[l] = quo_reg[QB-1][l];
    end

endmodule

>>> sv/spring_bungee_force.sv
`timescale 1ns / 1ps
// Hooke spring and bungee force on one particle, fully pipelined.
// Stages: three front stages, one per root bit of the square root, two magnitude
// stages, one per quotient bit of the divider, two back.
// Throughput is one item per cycle; a stall at the output holds every stage.
// Synchronous active-low reset clears all valid bits and loads k and rest length with 1.0.
module spring_bungee_force #(
    parameter int FRAC_BITS = sbf_pkg::FRAC_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [sbf_pkg::REG_IDX_W-1:0]  cfg_index,
    input  logic [31:0]                    cfg_wdata,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_mode,
    input  logic signed [31:0]             s_pos_x,
    input  logic signed [31:0]             s_pos_y,
    input  logic signed [31:0]             s_pos_z,
    input  logic signed [31:0]             s_end_x,
    input  logic signed [31:0]             s_end_y,
    input  logic signed [31:0]             s_end_z,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic signed [31:0]             m_force_x,
    output logic signed [31:0]             m_force_y,
    output logic signed [31:0]             m_force_z,
    output logic                           m_applied,
    output logic                           m_saturated
);
    import sbf_pkg::*;

    localparam int FL_W   = $bits(sbf_flags_t);
    localparam int KP_W   = COORD_W + ROOT_W;
    localparam int MAG_W  = KP_W - FRAC_BITS;
    localparam int QB     = FRAC_BITS + 1;
    localparam int NW     = DIFF_W + FRAC_BITS;
    localparam int P_W    = MAG_W + QB;
    localparam int F_W    = P_W - FRAC_BITS;
    localparam int SQ_SW  = 1 + LANES + LANES * DIFF_W;
    localparam int DV_SW  = FL_W + MAG_W;
    localparam logic [F_W-1:0] POS_MAX = F_W'(32'h7FFF_FFFF);
    localparam logic [F_W-1:0] NEG_MAX = F_W'(33'h0_8000_0000);

    logic en;
    logic [COORD_W-1:0] k_reg;
    logic [COORD_W-1:0] rest_reg;

    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            k_reg    <= CFG_RESET_VAL;
            rest_reg <= CFG_RESET_VAL;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_SPRING_K: k_reg    <= cfg_wdata;
                REG_REST_LEN: rest_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    logic [COORD_W-1:0] pos_in [LANES];
    logic [COORD_W-1:0] end_in [LANES];
    assign pos_in[0] = s_pos_x;
    assign pos_in[1] = s_pos_y;
    assign pos_in[2] = s_pos_z;
    assign end_in[0] = s_end_x;
    assign end_in[1] = s_end_y;
    assign end_in[2] = s_end_z;

    // Front: separation, squares, sum of squares.
    logic                s0_valid_reg, s1_valid_reg, s2_valid_reg;
    logic                s0_mode_reg, s1_mode_reg, s2_mode_reg;
    logic [LANES-1:0]    s0_dneg_reg, s1_dneg_reg, s2_dneg_reg;
    logic [DIFF_W-1:0]   s0_ad_reg [LANES];
    logic [DIFF_W-1:0]   s1_ad_reg [LANES];
    logic [DIFF_W-1:0]   s2_ad_reg [LANES];
    logic [SQ_SUM_W-1:0] s1_sq_reg [LANES];
    logic [SQ_SUM_W-1:0] s2_sum_reg;
    logic [DIFF_W-1:0]   d_next    [LANES];

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            d_next[l] = {pos_in[l][COORD_W-1], pos_in[l]} - {end_in[l][COORD_W-1], end_in[l]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end else if (en) begin
            s0_valid_reg <= s_valid;
            s1_valid_reg <= s0_valid_reg;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s0_mode_reg <= s_mode;
            s1_mode_reg <= s0_mode_reg;
            s2_mode_reg <= s1_mode_reg;
            s1_dneg_reg <= s0_dneg_reg;
            s2_dneg_reg <= s1_dneg_reg;
            for (int l = 0; l < LANES; l++) begin
                s0_dneg_reg[l] <= d_next[l][DIFF_W-1];
                s0_ad_reg[l]   <= d_next[l][DIFF_W-1] ? (~d_next[l] + 1'b1) : d_next[l];
                s1_ad_reg[l]   <= s0_ad_reg[l];
                s2_ad_reg[l]   <= s1_ad_reg[l];
                s1_sq_reg[l]   <= SQ_SUM_W'(s0_ad_reg[l]) * SQ_SUM_W'(s0_ad_reg[l]);
            end
            s2_sum_reg <= s1_sq_reg[0] + s1_sq_reg[1] + s1_sq_reg[2];
        end
    end

    // Square root of the sum.
    logic              sq_valid;
    logic [ROOT_W-1:0] sq_root;
    logic [SQ_SW-1:0]  sq_side;

    sbf_sqrt #(
        .SW(SQ_SW)
    ) u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (s2_valid_reg),
        .in_rad   ({{(2*ROOT_W-SQ_SUM_W){1'b0}}, s2_sum_reg}),
        .in_side  ({s2_mode_reg, s2_dneg_reg, s2_ad_reg[0], s2_ad_reg[1], s2_ad_reg[2]}),
        .out_valid(sq_valid),
        .out_root (sq_root),
        .out_side (sq_side)
    );

    logic              sq_mode;
    logic [LANES-1:0]  sq_dneg;
    logic [DIFF_W-1:0] sq_ad [LANES];
    logic [ROOT_W-1:0] rest_ext;
    sbf_flags_t        a_flags_next;

    assign {sq_mode, sq_dneg, sq_ad[0], sq_ad[1], sq_ad[2]} = sq_side;
    assign rest_ext = ROOT_W'(rest_reg);

    always_comb begin
        a_flags_next.fneg  = sq_root > rest_ext;
        a_flags_next.slack = sq_mode && !a_flags_next.fneg;
        a_flags_next.zero  = sq_root == '0;
        a_flags_next.dneg  = sq_dneg;
    end

    // Magnitude k * |rest - L|.
    logic              a_valid_reg, b_valid_reg;
    sbf_flags_t        a_flags_reg, b_flags_reg;
    logic [ROOT_W-1:0] a_len_reg, b_len_reg;
    logic [ROOT_W-1:0] a_dabs_reg;
    logic [DIFF_W-1:0] a_ad_reg [LANES];
    logic [DIFF_W-1:0] b_ad_reg [LANES];
    logic [MAG_W-1:0]  b_mag_reg;
    logic [KP_W-1:0]   kprod;

    assign kprod = KP_W'(k_reg) * KP_W'(a_dabs_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end else if (en) begin
            a_valid_reg <= sq_valid;
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_flags_reg <= a_flags_next;
            a_len_reg   <= sq_root;
            a_dabs_reg  <= a_flags_next.fneg ? (sq_root - rest_ext) : (rest_ext - sq_root);
            b_flags_reg <= a_flags_reg;
            b_len_reg   <= a_len_reg;
            b_mag_reg   <= kprod[KP_W-1:FRAC_BITS];
            for (int l = 0; l < LANES; l++) begin
                a_ad_reg[l] <= sq_ad[l];
                b_ad_reg[l] <= a_ad_reg[l];
            end
        end
    end

    // Unit direction |d| * 2^F / L.
    logic [NW-1:0]    dv_num [LANES];
    logic             dv_valid;
    logic [QB-1:0]    dv_quo [LANES];
    logic [DV_SW-1:0] dv_side;

    for (genvar l = 0; l < LANES; l++) begin : g_num
        assign dv_num[l] = {b_ad_reg[l], {FRAC_BITS{1'b0}}};
    end

    sbf_div #(
        .QB(QB),
        .DW(ROOT_W),
        .NW(NW),
        .SW(DV_SW)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (b_valid_reg),
        .in_num   (dv_num),
        .in_den   (b_len_reg),
        .in_side  ({b_flags_reg, b_mag_reg}),
        .out_valid(dv_valid),
        .out_quo  (dv_quo),
        .out_side (dv_side)
    );

    sbf_flags_t       dv_flags;
    logic [MAG_W-1:0] dv_mag;
    assign {dv_flags, dv_mag} = dv_side;

    // Component products and saturation.
    logic             c_valid_reg;
    sbf_flags_t       c_flags_reg;
    logic [P_W-1:0]   c_prod_reg [LANES];
    logic [COORD_W-1:0] force_next [LANES];
    logic             sat_next;
    logic             applied_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
        end else if (en) begin
            c_valid_reg <= dv_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            c_flags_reg <= dv_flags;
            for (int l = 0; l < LANES; l++) begin
                c_prod_reg[l] <= P_W'(dv_mag) * P_W'(dv_quo[l]);
            end
        end
    end

    always_comb begin
        logic [F_W-1:0] f;
        logic           neg;
        sat_next = 1'b0;
        for (int l = 0; l < LANES; l++) begin
            f   = c_prod_reg[l][P_W-1:FRAC_BITS];
            neg = c_flags_reg.fneg != c_flags_reg.dneg[l];
            if (neg) begin
                if (f > NEG_MAX) begin
                    force_next[l] = 32'h8000_0000;
                    sat_next      = 1'b1;
                end else begin
                    force_next[l] = ~f[COORD_W-1:0] + 1'b1;
                end
            end else begin
                if (f > POS_MAX) begin
                    force_next[l] = 32'h7FFF_FFFF;
                    sat_next      = 1'b1;
                end else begin
                    force_next[l] = f[COORD_W-1:0];
                end
            end
        end
        applied_next = !c_flags_reg.slack;
        if (c_flags_reg.slack || c_flags_reg.zero) begin
            for (int l = 0; l < LANES; l++) begin
                force_next[l] = '0;
            end
            sat_next = 1'b0;
        end
    end

    logic m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_force_x   <= force_next[0];
            m_force_y   <= force_next[1];
            m_force_z   <= force_next[2];
            m_applied   <= applied_next;
            m_saturated <= sat_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

>>> sv/sbf_checker.sv
`timescale 1ns / 1ps
// Port-level checks for spring_bungee_force, attached by the bind at the end.
// Depends only on the top-level ports of spring_bungee_force.
module sbf_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    input  logic                           s_ready,
    input  logic                           s_mode,
    input  logic signed [31:0]             s_pos_x,
    input  logic signed [31:0]             s_pos_y,
    input  logic signed [31:0]             s_pos_z,
    input  logic signed [31:0]             s_end_x,
    input  logic signed [31:0]             s_end_y,
    input  logic signed [31:0]             s_end_z,
    input  logic                           m_valid,
    input  logic                           m_ready,
    input  logic signed [31:0]             m_force_x,
    input  logic signed [31:0]             m_force_y,
    input  logic signed [31:0]             m_force_z,
    input  logic                           m_applied,
    input  logic                           m_saturated
);

    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_ready_follows_output: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready == (!m_valid || m_ready))
        else $error("input ready does not follow the output stage");

    a_input_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && !s_ready) |=> (s_valid && $stable({s_mode, s_pos_x, s_pos_y, s_pos_z,
                                                       s_end_x, s_end_y, s_end_z})))
        else $error("waiting input item changed or was withdrawn");

    a_slack_is_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_applied) |-> (m_force_x == 0 && m_force_y == 0 && m_force_z == 0
                                      && !m_saturated))
        else $error("slack item carries a force");

    a_sat_at_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_saturated) |->
            (m_force_x == 32'sh7FFF_FFFF || m_force_x == -32'sh8000_0000 ||
             m_force_y == 32'sh7FFF_FFFF || m_force_y == -32'sh8000_0000 ||
             m_force_z == 32'sh7FFF_FFFF || m_force_z == -32'sh8000_0000))
        else $error("saturated item has no clipped component");

endmodule

bind spring_bungee_force sbf_checker u_sbf_checker (.*);
